// ===== rtl/palm_database_header_checker_top_assert.svh =====
// Assertion macros for the database header checker top level.
// Depends on clk_i and rst_ni being visible at the point of use.
`ifndef PALM_DATABASE_HEADER_CHECKER_TOP_ASSERT_SVH
`define PALM_DATABASE_HEADER_CHECKER_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define PDHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdhc implication failed");

// Condition that must never hold outside reset.
`define PDHC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pdhc forbidden condition");

`endif

// ===== rtl/pdhc_pkg.sv =====
// Package for the database header checker: transfer types, codes, constants, check functions.
// No dependencies.
`timescale 1ns / 1ps
package pdhc_pkg;

  localparam int unsigned HdrBytes     = 78;
  localparam logic [15:0] ReservedMask = 16'h7000;
  localparam logic [7:0]  CodeLow      = 8'h20;
  localparam logic [7:0]  CodeHigh     = 8'h7e;
  localparam logic [31:0] TogoCode     = 32'h546F476F;
  localparam logic [3:0]  ResEntry     = 4'd10;
  localparam logic [3:0]  RecEntry     = 4'd8;
  localparam logic [31:0] MaxFiller    = 32'd2;
  localparam int unsigned FifoDepth    = 4;

  typedef enum logic [2:0] {
    KIND_APP     = 3'd0,
    KIND_SORT    = 3'd1,
    KIND_RECORD  = 3'd2,
    KIND_RES     = 3'd3,
    KIND_VERDICT = 3'd4
  } block_kind_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SMALL       = 4'd1,
    ST_BAD_NAME    = 4'd2,
    ST_RESERVED    = 4'd3,
    ST_BAD_CODE    = 4'd4,
    ST_NO_ENTRIES  = 4'd5,
    ST_OVERFLOW    = 4'd6,
    ST_BAD_RES     = 4'd7,
    ST_BAD_FILLER  = 4'd8,
    ST_ORDER       = 4'd9,
    ST_EMPTY_LAST  = 4'd10
  } check_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_t;

  typedef struct packed {
    block_kind_e   block_kind;
    logic [31:0]   block_offset;
    logic [31:0]   block_length;
    logic [31:0]   entry_ident;
    logic [15:0]   entry_flags;
    logic [15:0]   entry_number;
    logic          resource_kind;
    logic          togo_document;
    logic [15:0]   header_version;
    check_status_e check_status;
    logic          verdict_flag;
  } out_t;

  function automatic logic printable(input logic [31:0] v);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (v[8*i +: 8] < CodeLow || v[8*i +: 8] > CodeHigh) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic check_status_e off_check(input logic [31:0] off, input logic seen,
                                              input logic [31:0] prev,
                                              input logic [31:0] tend,
                                              input logic [31:0] flen);
    check_status_e st;
    st = ST_OK;
    if (!seen) begin
      if (off < tend || (off - tend) > MaxFiller) st = ST_BAD_FILLER;
    end else if (off < prev) begin
      st = ST_ORDER;
    end
    if (st == ST_OK && off > flen) st = ST_ORDER;
    return st;
  endfunction

endpackage

// ===== rtl/palm_database_header_checker_top.sv =====
// Latency: a result is offered the cycle after the byte that causes it transfers, if no result is queued ahead.
// Throughput: one byte per cycle while input ready is high; up to two results per byte through a 4-entry queue.
// Input ready drops while fewer than two queue slots are free.
// Reset: asynchronous active low; parse halted until a file start, length 0.
// Depends on pdhc_pkg and palm_database_header_checker_top_assert.svh.
`timescale 1ns / 1ps
module palm_database_header_checker_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pdhc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pdhc_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i
);
  import pdhc_pkg::*;
  `include "palm_database_header_checker_top_assert.svh"

  logic [31:0] fl_q;
  logic [19:0] pos_q, pos_d;
  logic        name_end_q, name_end_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] attr_q, attr_d, ver_q, ver_d, total_q, total_d;
  logic [31:0] type_q, type_d, creator_q, creator_d;
  logic        pv_q, pv_d;
  block_kind_e pk_q, pk_d;
  logic [31:0] po_q, po_d, pi_q, pi_d;
  logic [15:0] pf_q, pf_d, pn_q, pn_d;
  logic [31:0] prev_q, prev_d;
  logic        seen_q, seen_d, halted_q, halted_d;
  logic [31:0] app_q, app_d, sort_q, sort_d, ew_q, ew_d;
  logic [15:0] eh_q, eh_d, idx_q, idx_d;
  logic [3:0]  sub_q, sub_d;
  logic [19:0] tend_q, tend_d;

  logic          acc, start;
  logic [1:0]    n_res;
  out_t          r0, r1;
  logic [3:0]    esz;
  logic [19:0]   prod, tend_c;
  check_status_e st_a, st_b, st_t;
  logic          go;

  out_t        mem_q [FifoDepth];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;
  logic        pop;

  assign acc   = in_valid_i && in_ready_o;
  assign start = in_data_i.file_start;
  assign esz   = attr_q[0] ? ResEntry : RecEntry;
  assign prod  = {1'b0, shift_q[7:0], in_data_i.data_byte, 3'b000} +
                 (attr_q[0] ? {3'b000, shift_q[7:0], in_data_i.data_byte, 1'b0} : 20'd0);
  assign tend_c = 20'(HdrBytes) + prod;

  always_comb begin
    pos_d = pos_q; name_end_d = name_end_q; shift_d = shift_q;
    attr_d = attr_q; ver_d = ver_q; total_d = total_q;
    type_d = type_q; creator_d = creator_q;
    pv_d = pv_q; pk_d = pk_q; po_d = po_q; pi_d = pi_q; pf_d = pf_q; pn_d = pn_q;
    prev_d = prev_q; seen_d = seen_q; halted_d = halted_q;
    app_d = app_q; sort_d = sort_q; ew_d = ew_q; eh_d = eh_q;
    idx_d = idx_q; sub_d = sub_q; tend_d = tend_q;
    n_res = 2'd0; r0 = '0; r1 = '0;
    st_a = ST_OK; st_b = ST_OK; st_t = ST_OK;
    go = 1'b0;
    r0.block_kind = KIND_VERDICT; r0.check_status = ST_OK;
    r1.block_kind = KIND_VERDICT; r1.check_status = ST_OK;
    if (acc && start) begin
      pos_d = '0; name_end_d = 1'b0; shift_d = '0; attr_d = '0; ver_d = '0;
      total_d = '0; type_d = '0; creator_d = '0; pv_d = 1'b0; pk_d = KIND_APP;
      po_d = '0; pi_d = '0; pf_d = '0; pn_d = '0; prev_d = '0; seen_d = 1'b0;
      app_d = '0; sort_d = '0; ew_d = '0; eh_d = '0; idx_d = '0; sub_d = '0;
      tend_d = '0; halted_d = 1'b0;
      if (fl_q < 32'(HdrBytes + 1)) begin
        halted_d = 1'b1; n_res = 2'd1;
        r0.check_status = ST_SMALL; r0.verdict_flag = 1'b1;
      end else begin
        go = 1'b1;
      end
    end else if (acc && !halted_q) begin
      go = 1'b1;
    end
    if (go) begin
      shift_d = {(start ? 24'd0 : shift_q[23:0]), in_data_i.data_byte};
      pos_d   = (start ? 20'd0 : pos_q) + 20'd1;
      if (start || pos_q < 20'd32) begin
        if (!start && name_end_q) begin
          if (in_data_i.data_byte != 8'd0) begin
            n_res = 2'd1; r0.check_status = ST_BAD_NAME;
          end
        end else if (in_data_i.data_byte == 8'd0) begin
          if (start) begin
            n_res = 2'd1; r0.check_status = ST_BAD_NAME;
          end else begin
            name_end_d = 1'b1;
          end
        end else if (in_data_i.data_byte < CodeLow) begin
          n_res = 2'd1; r0.check_status = ST_BAD_NAME;
        end
        if (start && in_data_i.data_byte != 8'd0 && in_data_i.data_byte >= CodeLow) begin
          name_end_d = 1'b0;
        end
      end else if (pos_q == 20'h21) begin
        attr_d = shift_d[15:0];
        if ((shift_d[15:0] & ReservedMask) != 16'd0) begin
          n_res = 2'd1; r0.check_status = ST_RESERVED;
        end
      end else if (pos_q == 20'h23) begin
        ver_d = shift_d[15:0];
      end else if (pos_q == 20'h37) begin
        app_d = shift_d;
      end else if (pos_q == 20'h3b) begin
        sort_d = shift_d;
      end else if (pos_q == 20'h3f) begin
        type_d = shift_d;
      end else if (pos_q == 20'h43) begin
        creator_d = shift_d;
        if (!printable(type_q) || !printable(shift_d)) begin
          n_res = 2'd1; r0.check_status = ST_BAD_CODE;
        end
      end else if (pos_q == 20'(HdrBytes - 1)) begin
        total_d = shift_d[15:0];
        tend_d  = tend_c;
        sub_d   = '0;
        idx_d   = '0;
        if (shift_d[15:0] == 16'd0) begin
          n_res = 2'd1; r0.check_status = ST_NO_ENTRIES;
        end else if ({12'd0, tend_c} > fl_q) begin
          n_res = 2'd1; r0.check_status = ST_OVERFLOW;
        end else begin
          if (app_q != 32'd0) begin
            st_a = off_check(app_q, 1'b0, 32'd0, {12'd0, tend_c}, fl_q);
          end
          if (st_a != ST_OK) begin
            n_res = 2'd1; r0.check_status = st_a;
          end else begin
            if (app_q != 32'd0) begin
              pv_d = 1'b1; pk_d = KIND_APP; po_d = app_q; prev_d = app_q; seen_d = 1'b1;
            end
            if (sort_q != 32'd0) begin
              st_b = off_check(sort_q, seen_d, prev_d, {12'd0, tend_c}, fl_q);
              if (st_b != ST_OK) begin
                n_res = 2'd1; r0.check_status = st_b;
              end else begin
                if (pv_d) begin
                  n_res = 2'd1;
                  r0.block_kind = pk_d; r0.block_offset = po_d;
                  r0.block_length = sort_q - po_d;
                end
                pv_d = 1'b1; pk_d = KIND_SORT; po_d = sort_q; prev_d = sort_q;
                seen_d = 1'b1;
              end
            end
          end
        end
      end else if (pos_q >= 20'(HdrBytes)) begin
        if (sub_q == esz - 4'd1) begin
          sub_d = '0; idx_d = idx_q + 16'd1;
        end else begin
          sub_d = sub_q + 4'd1;
        end
        if (sub_q == 4'd3) begin
          ew_d = shift_d;
          if (attr_q[0] && !printable(shift_d)) begin
            n_res = 2'd1; r0.check_status = ST_BAD_RES;
          end
        end else if (attr_q[0] && sub_q == 4'd5) begin
          eh_d = shift_d[15:0];
        end else if (sub_q == esz - 4'd1) begin
          if (attr_q[0]) begin
            po_d = shift_d; pk_d = KIND_RES; pi_d = ew_q; pf_d = eh_q;
          end else begin
            po_d = ew_q; pk_d = KIND_RECORD; pi_d = {8'd0, shift_d[23:0]};
            pf_d = {8'd0, shift_d[31:24]};
          end
          pn_d = idx_q;
          st_t = off_check(po_d, seen_q, prev_q, {12'd0, tend_q}, fl_q);
          if (st_t != ST_OK) begin
            pk_d = pk_q; po_d = po_q; pi_d = pi_q; pf_d = pf_q; pn_d = pn_q;
            n_res = 2'd1; r0.check_status = st_t;
          end else begin
            if (pv_q) begin
              n_res = 2'd1;
              r0.block_kind = pk_q; r0.block_offset = po_q;
              r0.block_length = po_d - po_q; r0.entry_ident = pi_q;
              r0.entry_flags = pf_q; r0.entry_number = pn_q;
            end
            pv_d = 1'b1; prev_d = po_d; seen_d = 1'b1;
            if (idx_q + 16'd1 >= total_q) begin
              if (po_d >= fl_q) begin
                r1.check_status = ST_EMPTY_LAST; r1.verdict_flag = 1'b1;
              end else begin
                r1.block_kind = pk_d; r1.block_offset = po_d;
                r1.block_length = fl_q - po_d; r1.entry_ident = pi_d;
                r1.entry_flags = pf_d; r1.entry_number = pn_d; r1.verdict_flag = 1'b1;
                pv_d = 1'b0;
              end
              halted_d = 1'b1;
              if (pv_q) begin
                n_res = 2'd2;
              end else begin
                n_res = 2'd1; r0 = r1;
              end
            end
          end
        end
      end
      if (n_res != 2'd0 && r0.block_kind == KIND_VERDICT) begin
        r0.verdict_flag = 1'b1; halted_d = 1'b1;
      end
    end
    r0.resource_kind = attr_d[0]; r1.resource_kind = attr_d[0];
    r0.togo_document = (type_d == TogoCode) && (creator_d == TogoCode);
    r1.togo_document = r0.togo_document;
    r0.header_version = ver_d; r1.header_version = ver_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_q <= '0; pos_q <= '0; name_end_q <= 1'b0; shift_q <= '0; attr_q <= '0;
      ver_q <= '0; total_q <= '0; type_q <= '0; creator_q <= '0;
      pv_q <= 1'b0; pk_q <= KIND_APP; po_q <= '0; pi_q <= '0; pf_q <= '0; pn_q <= '0;
      prev_q <= '0; seen_q <= 1'b0; halted_q <= 1'b1; app_q <= '0; sort_q <= '0;
      ew_q <= '0; eh_q <= '0; idx_q <= '0; sub_q <= '0; tend_q <= '0;
    end else begin
      if (cfg_we_i) fl_q <= cfg_wdata_i;
      pos_q <= pos_d; name_end_q <= name_end_d; shift_q <= shift_d; attr_q <= attr_d;
      ver_q <= ver_d; total_q <= total_d; type_q <= type_d; creator_q <= creator_d;
      pv_q <= pv_d; pk_q <= pk_d; po_q <= po_d; pi_q <= pi_d; pf_q <= pf_d; pn_q <= pn_d;
      prev_q <= prev_d; seen_q <= seen_d; halted_q <= halted_d;
      app_q <= app_d; sort_q <= sort_d; ew_q <= ew_d; eh_q <= eh_d;
      idx_q <= idx_d; sub_q <= sub_d; tend_q <= tend_d;
    end
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_data_o  = mem_q[rd_q];
  assign in_ready_o  = cnt_q <= 3'(FifoDepth - 2);

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) mem_q[wr_q] <= r0;
    if (n_res == 2'd2) mem_q[wr_q + 2'd1] <= r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_res;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {1'b0, n_res} - {2'b00, pop};
    end
  end

  `PDHC_ASSERT_NEVER(a_fifo_bound, cnt_q > 3'(FifoDepth))
  `PDHC_ASSERT_IMP(a_halted_silent, acc && !start && halted_q, n_res == 2'd0)
  `PDHC_ASSERT_IMP(a_status_final, out_valid_o && !out_data_o.verdict_flag,
                   out_data_o.check_status == ST_OK)
  `PDHC_ASSERT_IMP(a_verdict_halts, n_res != 2'd0 && !halted_d, !halted_q)

endmodule
